// File: sv/deadlock_cycle_detector_top_macros.svh
// ----------------------------------------------------------------------------
// Deadlock cycle detector assertion macros
// Clocked on aclk, disabled while aresetn is low.
// ----------------------------------------------------------------------------
`ifndef DEADLOCK_CYCLE_DETECTOR_TOP_MACROS_SVH
`define DEADLOCK_CYCLE_DETECTOR_TOP_MACROS_SVH

// Property must hold at every edge out of reset
`define DCD_ASSERT(name, prop, msg) \
    name: assert property (@(posedge aclk) disable iff (!aresetn) prop) \
        else $error(msg);

// Condition must never be seen out of reset
`define DCD_ASSERT_NEVER(name, cond, msg) \
    `DCD_ASSERT(name, !(cond), msg)

`endif

// File: sv/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared field widths and the structs passed between front, queue and back.
// ----------------------------------------------------------------------------
package dcd_pkg;

    localparam int PROC_IDX_W = 4;
    localparam int MARK_W     = 2;
    localparam int HOLDER_W   = 4;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 16;

    // Classified update command, front to back
    typedef struct packed {
        logic                  write_en;
        logic [PROC_IDX_W-1:0] proc_idx;
        logic [MARK_W-1:0]     mark_two;
        logic [MARK_W-1:0]     mark_one;
    } cmd_t;

    // Check result, back to output
    typedef struct packed {
        logic                deadlock_found;
        logic [HOLDER_W-1:0] first_holder;
        logic [HOLDER_W-1:0] second_holder;
    } result_t;

endpackage

// File: sv/deadlock_cycle_detector_top.sv
// ----------------------------------------------------------------------------
// deadlock_cycle_detector_top
// Resource allocation graph deadlock checker for two resources.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (s_*): one beat rewrites the two resource marks of one
//   process (0 none, 1 requested, 2 holding). An index beyond the process
//   count changes nothing but still yields a result.
//   Master channel (m_*): exactly one result beat per input beat, in order:
//   deadlock flag plus the processes on the found cycle holding resource 1
//   and resource 2 (zero when absent).
//   A beat passes the input register and the queue hand-off, then the
//   search sequencer takes one graph step per cycle; a found cycle cuts
//   the search short. Throughput is one beat per search, set by that
//   sequencer.
//   A two-entry queue sits between the input register and the sequencer,
//   so up to three further beats are taken while a search runs.
//   While m_tready is low the finished result is held in the output
//   register; the sequencer can finish the next search and then waits.
//   Reset (aresetn low, synchronous) clears all marks to none and empties
//   the queue and output register.
// ----------------------------------------------------------------------------
module deadlock_cycle_detector_top #(
    parameter int PROCESS_COUNT = 10
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [3:0] process_index, [5:4] first_resource_mark, [7:6] second_resource_mark
    input  logic [dcd_pkg::S_TDATA_W-1:0] s_tdata,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [0] deadlock_found, [4:1] first_resource_holder,
    // [8:5] second_resource_holder, [15:9] zero
    output logic [dcd_pkg::M_TDATA_W-1:0] m_tdata
);
    import dcd_pkg::*;

    localparam int ResultW = 1 + 2 * HOLDER_W;

    cmd_t    f_cmd, q_cmd;
    logic    f_valid, f_ready;
    logic    q_valid, q_pop;
    result_t result;

    dcd_front #(
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .f_valid  (f_valid),
        .f_ready  (f_ready),
        .f_cmd    (f_cmd)
    );

    dcd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (f_valid),
        .push_ready (f_ready),
        .push_cmd   (f_cmd),
        .pop_valid  (q_valid),
        .pop        (q_pop),
        .pop_cmd    (q_cmd)
    );

    dcd_back #(
        .PROCESS_COUNT (PROCESS_COUNT)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_pop    (q_pop),
        .q_cmd    (q_cmd),
        .m_valid  (m_tvalid),
        .m_ready  (m_tready),
        .m_result (result)
    );

    // Pack result beat
    assign m_tdata = {(M_TDATA_W - ResultW)'(0), result.second_holder,
                      result.first_holder, result.deadlock_found};

endmodule

// File: sv/dcd_front.sv
// ----------------------------------------------------------------------------
// dcd_front
// Input beat register: unpacks the beat and flags whether it targets a
// process that exists.
// ----------------------------------------------------------------------------
module dcd_front #(
    parameter int PROCESS_COUNT = 10
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [dcd_pkg::S_TDATA_W-1:0]   s_tdata,
    output logic                            f_valid,
    input  logic                            f_ready,
    output dcd_pkg::cmd_t                   f_cmd
);
    import dcd_pkg::*;

    localparam logic [PROC_IDX_W:0] IdxLimit = (PROC_IDX_W+1)'(PROCESS_COUNT);

    logic [PROC_IDX_W-1:0] in_idx;
    logic                  s_fire;
    logic                  valid_reg, valid_next;
    cmd_t                  cmd_reg, cmd_next;

    // Unpack beat
    assign in_idx   = s_tdata[PROC_IDX_W-1:0];
    assign s_tready = !valid_reg || f_ready;
    assign s_fire   = s_tvalid && s_tready;

    always_comb begin
        valid_next = s_fire || (valid_reg && !f_ready);
        cmd_next   = cmd_reg;
        if (s_fire) begin
            cmd_next.write_en = ({1'b0, in_idx} < IdxLimit);
            cmd_next.proc_idx = in_idx;
            cmd_next.mark_one = s_tdata[PROC_IDX_W +: MARK_W];
            cmd_next.mark_two = s_tdata[PROC_IDX_W+MARK_W +: MARK_W];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
        cmd_reg <= cmd_next;
    end

    assign f_valid = valid_reg;
    assign f_cmd   = cmd_reg;

endmodule

// File: sv/dcd_queue.sv
// ----------------------------------------------------------------------------
// dcd_queue
// Two-entry command queue between the front register and the search engine.
// ----------------------------------------------------------------------------
module dcd_queue (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          push_valid,
    output logic          push_ready,
    input  dcd_pkg::cmd_t push_cmd,
    output logic          pop_valid,
    input  logic          pop,
    output dcd_pkg::cmd_t pop_cmd
);
    import dcd_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop && pop_valid;

    // Pointer and occupancy update
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ do_push;
        rd_ptr_next = rd_ptr_reg ^ do_pop;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: sv/dcd_back.sv
// ----------------------------------------------------------------------------
// dcd_back
// Mark store and depth-first cycle search sequencer. One graph step per
// cycle; a found cycle is then walked back along the search path to pick the holders.
// ----------------------------------------------------------------------------
`include "deadlock_cycle_detector_top_macros.svh"

module dcd_back #(
    parameter int PROCESS_COUNT = 10
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             q_valid,
    output logic             q_pop,
    input  dcd_pkg::cmd_t    q_cmd,
    output logic             m_valid,
    input  logic             m_ready,
    output dcd_pkg::result_t m_result
);
    import dcd_pkg::*;

    localparam int NodeCount = PROCESS_COUNT + 2;
    localparam int NW        = $clog2(NodeCount);
    localparam int PW        = $clog2(PROCESS_COUNT);
    localparam logic [NW-1:0] ResOne = NW'(PROCESS_COUNT);
    localparam logic [NW-1:0] ResTwo = NW'(PROCESS_COUNT + 1);

    localparam logic [MARK_W-1:0] MarkRequest = 2'd1;
    localparam logic [MARK_W-1:0] MarkHold    = 2'd2;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROOT,
        ST_STEP,
        ST_WALK,
        ST_DONE
    } state_t;

    state_t                     state_reg, state_next;
    logic [2*MARK_W-1:0]        marks_reg [PROCESS_COUNT];
    logic [2*MARK_W-1:0]        marks_next [PROCESS_COUNT];
    logic [NodeCount-1:0]       onpath_reg, onpath_next;
    logic [NodeCount-1:0]       done_reg, done_next;
    logic [NW-1:0]              parent_reg [NodeCount];
    logic [NW-1:0]              cur_reg, cur_next;
    logic [NW-1:0]              root_reg, root_next;
    logic [NW-1:0]              start_reg, start_next;
    logic [HOLDER_W-1:0]        h1_reg, h1_next;
    logic [HOLDER_W-1:0]        h2_reg, h2_next;
    logic                       found_reg, found_next;
    logic                       m_valid_reg, m_valid_next;
    result_t                    out_reg, out_next;
    logic                       parent_we;

    logic [PROCESS_COUNT-1:0]   req1, req2, hold1, hold2;
    logic [PW-1:0]              cur_proc;
    logic                       cur_is_proc;
    logic [NodeCount-1:0]       adj, cand, free_nodes;
    logic [NW-1:0]              first_cand, first_free;

    // Lowest set bit of a node vector
    function automatic logic [NW-1:0] lowest(input logic [NodeCount-1:0] v);
        logic [NW-1:0] idx;
        idx = '0;
        for (int i = NodeCount - 1; i >= 0; i--) begin
            if (v[i]) idx = NW'(i);
        end
        return idx;
    endfunction

    // Edge vectors per process
    always_comb begin
        for (int p = 0; p < PROCESS_COUNT; p++) begin
            req1[p]  = (marks_reg[p][MARK_W-1:0] == MarkRequest);
            req2[p]  = (marks_reg[p][2*MARK_W-1:MARK_W] == MarkRequest);
            hold1[p] = (marks_reg[p][MARK_W-1:0] == MarkHold);
            hold2[p] = (marks_reg[p][2*MARK_W-1:MARK_W] == MarkHold);
        end
    end

    // Out-edges of the current node: process to resource on request,
    // resource to process on hold
    assign cur_proc    = cur_reg[PW-1:0];
    assign cur_is_proc = (cur_reg < ResOne);

    always_comb begin
        adj = '0;
        if (cur_is_proc) begin
            adj[PROCESS_COUNT]     = req1[cur_proc];
            adj[PROCESS_COUNT + 1] = req2[cur_proc];
        end else if (cur_reg == ResOne) begin
            adj[PROCESS_COUNT-1:0] = hold1;
        end else if (cur_reg == ResTwo) begin
            adj[PROCESS_COUNT-1:0] = hold2;
        end
    end

    // Finished nodes are skipped; all earlier neighbors are finished when
    // the search comes back, so no resume index is kept
    assign cand       = adj & ~done_reg;
    assign free_nodes = ~(onpath_reg | done_reg);
    assign first_cand = lowest(cand);
    assign first_free = lowest(free_nodes);

    // Sequencer
    always_comb begin
        state_next   = state_reg;
        marks_next   = marks_reg;
        onpath_next  = onpath_reg;
        done_next    = done_reg;
        cur_next     = cur_reg;
        root_next    = root_reg;
        start_next   = start_reg;
        h1_next      = h1_reg;
        h2_next      = h2_reg;
        found_next   = found_reg;
        out_next     = out_reg;
        m_valid_next = m_valid_reg && !m_ready;
        q_pop        = 1'b0;
        parent_we    = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_pop = 1'b1;
                    if (q_cmd.write_en) begin
                        marks_next[q_cmd.proc_idx[PW-1:0]] = {q_cmd.mark_two, q_cmd.mark_one};
                    end
                    onpath_next = '0;
                    done_next   = '0;
                    state_next  = ST_ROOT;
                end
            end
            ST_ROOT: begin
                if (free_nodes == '0) begin
                    found_next = 1'b0;
                    h1_next    = '0;
                    h2_next    = '0;
                    state_next = ST_DONE;
                end else begin
                    cur_next                = first_free;
                    root_next               = first_free;
                    onpath_next[first_free] = 1'b1;
                    state_next              = ST_STEP;
                end
            end
            ST_STEP: begin
                if (cand == '0) begin
                    // Backtrack
                    onpath_next[cur_reg] = 1'b0;
                    done_next[cur_reg]   = 1'b1;
                    if (cur_reg == root_reg) begin
                        state_next = ST_ROOT;
                    end else begin
                        cur_next = parent_reg[cur_reg];
                    end
                end else if (onpath_reg[first_cand]) begin
                    // Back edge closes a cycle
                    start_next = first_cand;
                    h1_next    = '0;
                    h2_next    = '0;
                    state_next = ST_WALK;
                end else begin
                    onpath_next[first_cand] = 1'b1;
                    parent_we               = 1'b1;
                    cur_next                = first_cand;
                end
            end
            ST_WALK: begin
                // Walk from closing node toward cycle start; last holder wins
                if (cur_is_proc) begin
                    if (hold1[cur_proc]) h1_next = HOLDER_W'(cur_reg);
                    if (hold2[cur_proc]) h2_next = HOLDER_W'(cur_reg);
                end
                if (cur_reg == start_reg) begin
                    found_next = 1'b1;
                    state_next = ST_DONE;
                end else begin
                    cur_next = parent_reg[cur_reg];
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_ready) begin
                    out_next.deadlock_found = found_reg;
                    out_next.first_holder   = h1_reg;
                    out_next.second_holder  = h2_reg;
                    m_valid_next            = 1'b1;
                    state_next              = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            onpath_reg  <= '0;
            done_reg    <= '0;
            m_valid_reg <= 1'b0;
            for (int p = 0; p < PROCESS_COUNT; p++) begin
                marks_reg[p] <= '0;
            end
        end else begin
            state_reg   <= state_next;
            onpath_reg  <= onpath_next;
            done_reg    <= done_next;
            m_valid_reg <= m_valid_next;
            marks_reg   <= marks_next;
        end
        cur_reg   <= cur_next;
        root_reg  <= root_next;
        start_reg <= start_next;
        h1_reg    <= h1_next;
        h2_reg    <= h2_next;
        found_reg <= found_next;
        out_reg   <= out_next;
        if (parent_we) begin
            parent_reg[first_cand] <= cur_reg;
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_result = out_reg;

    // Checks
    `DCD_ASSERT_NEVER(a_path_done_overlap, (onpath_reg & done_reg) != '0,
        "node both on path and finished")
    `DCD_ASSERT(a_walk_on_path, state_reg == ST_WALK |-> onpath_reg[cur_reg],
        "holder walk left the search path")
    `DCD_ASSERT(a_load_from_done, $rose(m_valid_reg) |-> $past(state_reg == ST_DONE),
        "result loaded outside done state")
    `DCD_ASSERT(a_clear_no_holder,
        m_valid_reg && !out_reg.deadlock_found |->
            (out_reg.first_holder == '0) && (out_reg.second_holder == '0),
        "holder reported without a cycle")

endmodule

// File: tb/tb_deadlock_cycle_detector_top.sv
// ----------------------------------------------------------------------------
// tb_deadlock_cycle_detector_top
// Drives mark updates into the deadlock detector with random source gaps and
// sink stalls. A local copy of the process marks is kept, and the resource
// allocation graph is searched depth first after every accepted beat. Each
// result beat is checked against the oldest pending verdict.
// ----------------------------------------------------------------------------
module tb_deadlock_cycle_detector_top;
    timeunit 1ns;
    timeprecision 1ps;

    import dcd_pkg::*;

    localparam int PROCESS_COUNT = 10;
    localparam int NODE_COUNT    = PROCESS_COUNT + 2;
    localparam int RES_ONE_NODE  = PROCESS_COUNT;
    localparam int RES_TWO_NODE  = PROCESS_COUNT + 1;
    localparam int MAX_REPORTS   = 10;
    localparam int DRAIN_CYCLES  = 64;
    localparam int TIMEOUT_NS    = 12_000_000;

    // Per-resource mark encoding; value three is stored but adds no edge
    typedef enum logic [MARK_W-1:0] {
        MARK_NONE      = 2'd0,
        MARK_REQUESTED = 2'd1,
        MARK_HOLDING   = 2'd2,
        MARK_UNUSED    = 2'd3
    } mark_e;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    // [3:0] process_index, [5:4] first_resource_mark, [7:6] second_resource_mark
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    // [0] deadlock_found, [4:1] first_resource_holder,
    // [8:5] second_resource_holder, [15:9] zero
    logic [M_TDATA_W-1:0]  m_tdata;

    // Local copy of the marks: [1:0] resource 1, [3:2] resource 2
    logic [2*MARK_W-1:0]   proc_marks [PROCESS_COUNT];
    result_t               pending_verdicts [$];
    int                    error_count   = 0;
    int                    results_seen  = 0;
    int                    send_quiet    = 0;
    int                    recv_quiet    = 0;
    int                    recv_stall    = 0;

    deadlock_cycle_detector_top #(
        .PROCESS_COUNT(PROCESS_COUNT)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    // ------------------------------------------------------------------------
    // Graph model
    // ------------------------------------------------------------------------
    function automatic logic [MARK_W-1:0] mark_of(input int proc, input int res);
        return proc_marks[proc][2*res +: MARK_W];
    endfunction

    // Request: process -> resource. Holding: resource -> process.
    function automatic bit rag_edge(input int u, input int v);
        if (u < PROCESS_COUNT && v >= PROCESS_COUNT && v < NODE_COUNT)
            return mark_of(u, v - PROCESS_COUNT) == MARK_REQUESTED;
        if (u >= PROCESS_COUNT && u < NODE_COUNT && v < PROCESS_COUNT)
            return mark_of(v, u - PROCESS_COUNT) == MARK_HOLDING;
        return 1'b0;
    endfunction

    // Depth-first search, roots and neighbors in ascending order, stopping at
    // the first back edge; holders are taken walking the path back from the
    // node that closed the cycle, so the last process seen wins.
    function automatic result_t search_deadlock();
        int      color   [NODE_COUNT];
        int      parent  [NODE_COUNT];
        int      next_nb [NODE_COUNT];
        int      path    [NODE_COUNT];
        int      depth;
        int      v;
        int      j;
        int      node;
        int      close_to;
        int      close_from;
        bit      found;
        result_t verdict;

        verdict    = '0;
        found      = 1'b0;
        close_to   = 0;
        close_from = 0;
        for (int i = 0; i < NODE_COUNT; i++) begin
            color[i]   = 0;
            parent[i]  = -1;
            next_nb[i] = 0;
        end

        for (int root = 0; root < NODE_COUNT && !found; root++) begin
            if (color[root] == 0) begin
                color[root] = 1;
                path[0]     = root;
                depth       = 1;
                while (depth > 0 && !found) begin
                    v = path[depth-1];
                    if (next_nb[v] == NODE_COUNT) begin
                        color[v] = 2;
                        depth--;
                    end else begin
                        j = next_nb[v];
                        next_nb[v]++;
                        if (rag_edge(v, j)) begin
                            if (color[j] == 1) begin
                                found      = 1'b1;
                                close_to   = j;
                                close_from = v;
                            end else if (color[j] == 0) begin
                                color[j]    = 1;
                                parent[j]   = v;
                                path[depth] = j;
                                depth++;
                            end
                        end
                    end
                end
            end
        end

        if (found) begin
            verdict.deadlock_found = 1'b1;
            node = close_from;
            for (int s = 0; s <= NODE_COUNT; s++) begin
                if (node < 0 || node >= NODE_COUNT)
                    break;
                if (node < PROCESS_COUNT) begin
                    if (rag_edge(RES_ONE_NODE, node))
                        verdict.first_holder = HOLDER_W'(node);
                    if (rag_edge(RES_TWO_NODE, node))
                        verdict.second_holder = HOLDER_W'(node);
                end
                if (node == close_to)
                    break;
                node = parent[node];
            end
        end
        return verdict;
    endfunction

    // ------------------------------------------------------------------------
    // Idle length: mostly none, some short, a few long, with quiet stretches
    // ------------------------------------------------------------------------
    function automatic int pick_idle(inout int quiet_left);
        int r;
        if (quiet_left > 0) begin
            quiet_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            quiet_left = $urandom_range(20, 60);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [MARK_W-1:0] rand_mark();
        return MARK_W'($urandom_range(0, 3));
    endfunction

    // ------------------------------------------------------------------------
    // Source side: one update beat, predicted once accepted
    // ------------------------------------------------------------------------
    task automatic send_update(input logic [PROC_IDX_W-1:0] idx,
                               input logic [MARK_W-1:0] res_one_mark,
                               input logic [MARK_W-1:0] res_two_mark);
        int gap;
        s_tvalid <= 1'b1;
        s_tdata  <= {res_two_mark, res_one_mark, idx};
        do @(posedge aclk); while (!s_tready);

        if (idx < PROCESS_COUNT)
            proc_marks[idx] = {res_two_mark, res_one_mark};
        pending_verdicts.push_back(search_deadlock());

        gap = pick_idle(send_quiet);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
    endtask

    task automatic send_noise(input int count);
        repeat (count)
            send_update(PROC_IDX_W'($urandom_range(0, 15)), rand_mark(), rand_mark());
    endtask

    // ------------------------------------------------------------------------
    // Sink side: random stalls, every beat checked against the oldest verdict
    // ------------------------------------------------------------------------
    task automatic note_failure(input string msg);
        error_count++;
        if (error_count <= MAX_REPORTS)
            $display("[%0t] mismatch: %s", $realtime, msg);
    endtask

    task automatic check_result(input logic [M_TDATA_W-1:0] beat);
        result_t             want;
        logic                got_found;
        logic [HOLDER_W-1:0] got_one;
        logic [HOLDER_W-1:0] got_two;
        got_found = beat[0];
        got_one   = beat[4:1];
        got_two   = beat[8:5];
        if (pending_verdicts.size() == 0) begin
            note_failure($sformatf("result beat %h arrived with nothing pending", beat));
        end else begin
            want = pending_verdicts.pop_front();
            if (got_found !== want.deadlock_found || got_one !== want.first_holder ||
                got_two !== want.second_holder)
                note_failure($sformatf(
                    "beat %0d expected found=%0d r1=%0d r2=%0d, got found=%0d r1=%0d r2=%0d",
                    results_seen, want.deadlock_found, want.first_holder,
                    want.second_holder, got_found, got_one, got_two));
        end
        results_seen++;
    endtask

    always @(posedge aclk) begin
        int stall;
        if (aresetn) begin
            if (m_tvalid && m_tready)
                check_result(m_tdata);
            if (recv_stall > 0) begin
                recv_stall--;
                m_tready <= 1'b0;
            end else begin
                stall = pick_idle(recv_quiet);
                if (stall > 0) begin
                    recv_stall = stall - 1;
                    m_tready   <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        end
    end

    // ------------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------------
    // Field extremes, mark three, out-of-range indexes, making and breaking
    // a cycle, holder at process zero
    task automatic test_directed();
        send_update(4'd0,  MARK_NONE,      MARK_NONE);
        send_update(4'd0,  MARK_HOLDING,   MARK_REQUESTED);
        send_update(4'd9,  MARK_REQUESTED, MARK_HOLDING);   // cycle P0/P9
        send_update(4'd10, MARK_HOLDING,   MARK_HOLDING);   // ignored, still cycle
        send_update(4'd15, MARK_UNUSED,    MARK_UNUSED);    // ignored
        send_update(4'd9,  MARK_REQUESTED, MARK_UNUSED);    // mark three: no edge
        send_update(4'd9,  MARK_UNUSED,    MARK_HOLDING);
        send_update(4'd5,  MARK_REQUESTED, MARK_HOLDING);   // cycle P0/P5
        send_update(4'd3,  MARK_HOLDING,   MARK_REQUESTED); // second R1 holder
        send_update(4'd0,  MARK_NONE,      MARK_NONE);
        send_update(4'd3,  MARK_NONE,      MARK_NONE);
        send_update(4'd9,  MARK_HOLDING,   MARK_REQUESTED); // cycle P9/P5
        send_update(4'd8,  MARK_HOLDING,   MARK_HOLDING);
        send_update(4'd7,  MARK_REQUESTED, MARK_REQUESTED);
        send_update(4'd9,  MARK_NONE,      MARK_NONE);
        send_update(4'd5,  MARK_NONE,      MARK_NONE);
        send_update(4'd8,  MARK_NONE,      MARK_NONE);
        send_update(4'd7,  MARK_NONE,      MARK_NONE);
        send_update(4'd1,  MARK_HOLDING,   MARK_HOLDING);
        send_update(4'd2,  MARK_REQUESTED, MARK_REQUESTED);
        send_update(4'd1,  MARK_REQUESTED, MARK_REQUESTED); // requests only
        send_update(4'd2,  MARK_NONE,      MARK_NONE);
        send_update(4'd1,  MARK_NONE,      MARK_NONE);
        send_update(4'd12, MARK_REQUESTED, MARK_HOLDING);
    endtask

    // Unbiased updates over every index and mark value
    task automatic test_random_noise(input int item_budget);
        send_noise(item_budget);
    endtask

    // Two processes each holding one resource and wanting the other, built
    // in random order among clears and noise, then often broken again
    task automatic test_random_deadlocks(input int item_budget);
        int sent;
        int proc_a;
        int proc_b;
        int n;
        sent = 0;
        while (sent < item_budget) begin
            proc_a = $urandom_range(0, PROCESS_COUNT - 1);
            proc_b = (proc_a + $urandom_range(1, PROCESS_COUNT - 1)) % PROCESS_COUNT;

            n = $urandom_range(0, 3);
            repeat (n)
                send_update(PROC_IDX_W'($urandom_range(0, PROCESS_COUNT - 1)),
                            MARK_NONE, MARK_NONE);
            sent += n;

            if ($urandom_range(0, 1))
                send_update(PROC_IDX_W'(proc_a), MARK_HOLDING, MARK_REQUESTED);
            else
                send_update(PROC_IDX_W'(proc_b), MARK_REQUESTED, MARK_HOLDING);
            n = $urandom_range(0, 3);
            send_noise(n);
            sent += n + 1;
            if (proc_marks[proc_a] != {MARK_REQUESTED, MARK_HOLDING})
                send_update(PROC_IDX_W'(proc_a), MARK_HOLDING, MARK_REQUESTED);
            else
                send_update(PROC_IDX_W'(proc_b), MARK_REQUESTED, MARK_HOLDING);
            sent++;

            n = $urandom_range(0, 2);
            send_noise(n);
            sent += n;

            if ($urandom_range(0, 1)) begin
                send_update(PROC_IDX_W'($urandom_range(0, 1) ? proc_a : proc_b),
                            rand_mark(), rand_mark());
                sent++;
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------------
    initial begin
        for (int i = 0; i < PROCESS_COUNT; i++)
            proc_marks[i] = '0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_random_noise(400);
        test_random_deadlocks(1480);

        s_tvalid <= 1'b0;
        while (pending_verdicts.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);

        if (error_count == 0 && pending_verdicts.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    // Hang guard
    initial begin
        #(TIMEOUT_NS);
        $display("FAILURE");
        $finish;
    end

endmodule

// File: deadlock_cycle_detector_top.f
+incdir+sv
sv/dcd_pkg.sv
sv/dcd_front.sv
sv/dcd_queue.sv
sv/dcd_back.sv
sv/deadlock_cycle_detector_top.sv
tb/tb_deadlock_cycle_detector_top.sv
